// ===== sv/mld_pkg.sv =====
package mld_pkg;

    localparam logic [63:0] SYNC_PATTERN = 64'h3133_7359_3723_337E;

    // One result item as it travels from the frame logic to the output queue.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } t_result;

endpackage

// ===== sv/mld_core.sv =====
module mld_core
    import mld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [63:0] r_window,     n_window;
    logic [1:0]  r_len_idx,    n_len_idx;
    logic [31:0] r_len_acc,    n_len_acc;
    logic [31:0] r_remaining,  n_remaining;
    logic        r_frame_start, n_frame_start;

    logic [63:0] shifted;
    logic        last_byte;

    assign shifted   = {r_window[55:0], i_byte};
    assign last_byte = (r_remaining <= 32'd1);

    always_comb begin
        n_phase       = r_phase;
        n_window      = r_window;
        n_len_idx     = r_len_idx;
        n_len_acc     = r_len_acc;
        n_remaining   = r_remaining;
        n_frame_start = r_frame_start;
        o_res_valid   = 1'b0;
        o_res         = '0;

        case (r_phase)
            PH_LEN: begin
                case (r_len_idx)
                    2'd0:    n_len_acc[7:0]   = r_len_acc[7:0]   | i_byte;
                    2'd1:    n_len_acc[15:8]  = r_len_acc[15:8]  | i_byte;
                    2'd2:    n_len_acc[23:16] = r_len_acc[23:16] | i_byte;
                    default: n_len_acc[31:24] = r_len_acc[31:24] | i_byte;
                endcase
                if (r_len_idx == 2'd3) begin
                    if (n_len_acc == 32'd0) begin
                        // empty frame: emit a marker, then hunt again
                        o_res_valid          = 1'b1;
                        o_res.first_of_frame = 1'b1;
                        o_res.last_of_frame  = 1'b1;
                        n_phase              = PH_HUNT;
                        n_window             = '0;
                        n_len_idx            = '0;
                        n_len_acc            = '0;
                        n_remaining          = '0;
                        n_frame_start        = 1'b0;
                    end else begin
                        n_remaining   = n_len_acc;
                        n_frame_start = 1'b1;
                        n_len_idx     = '0;
                        n_phase       = PH_DATA;
                    end
                end else begin
                    n_len_idx = r_len_idx + 2'd1;
                end
            end
            PH_DATA: begin
                o_res_valid          = 1'b1;
                o_res.payload_byte   = i_byte;
                o_res.has_byte       = 1'b1;
                o_res.first_of_frame = r_frame_start;
                o_res.last_of_frame  = last_byte;
                n_frame_start        = 1'b0;
                if (last_byte) begin
                    n_phase     = PH_HUNT;
                    n_window    = '0;
                    n_len_idx   = '0;
                    n_len_acc   = '0;
                    n_remaining = '0;
                end else begin
                    n_remaining = r_remaining - 32'd1;
                end
            end
            default: begin
                // hunt: slide the window and look for the sync pattern
                if (shifted == SYNC_PATTERN) begin
                    n_window      = '0;
                    n_phase       = PH_LEN;
                    n_len_idx     = '0;
                    n_len_acc     = '0;
                    n_remaining   = '0;
                    n_frame_start = 1'b0;
                end else begin
                    n_window = shifted;
                    n_phase  = PH_HUNT;
                end
            end
        endcase

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_window      <= '0;
            r_len_idx     <= '0;
            r_len_acc     <= '0;
            r_remaining   <= '0;
            r_frame_start <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_window      <= n_window;
            r_len_idx     <= n_len_idx;
            r_len_acc     <= n_len_acc;
            r_remaining   <= n_remaining;
            r_frame_start <= n_frame_start;
        end
    end

endmodule

// ===== sv/mld_out_queue.sv =====
module mld_out_queue
    import mld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/magic_length_deframer.sv =====
// Sync-and-length deframer for a byte stream.
//
// Input channel: i_in_valid / o_in_ready carry one received byte per transfer
// on i_data_byte. The block hunts for the 8-byte sync pattern
// 31 33 73 59 37 23 33 7E, reads a 4-byte little-endian length, then
// forwards that many payload bytes. Header bytes and bytes between frames
// are dropped. A zero length gives one empty-frame marker (has_byte low,
// first and last high, payload zero).
// Output channel: o_out_valid / i_out_ready carry payload_byte, has_byte,
// first_of_frame and last_of_frame.
// Path: the byte that causes a result passes the input register, then the frame
// logic, which pushes the result into a 2-entry output queue; the result can
// transfer out from the head of that queue.
// Throughput: one byte per cycle, sustained while the receiver takes results.
// Stall: the output queue absorbs results while the receiver holds off; once
// it is full the frame logic holds and o_in_ready drops after the input
// register fills. Nothing is lost or repeated.
// Reset: synchronous, active low; clears the hunt state, the input register
// and the output queue. o_in_ready is high right after reset.
module magic_length_deframer
    import mld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_has_byte,
    output logic       o_first_of_frame,
    output logic       o_last_of_frame
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       q_full;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    head;

    // advance the held byte only when the queue has room for its result
    assign step       = r_in_valid && !q_full;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    mld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mld_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .o_data  (head),
        .i_ready (i_out_ready)
    );

    assign o_payload_byte   = head.payload_byte;
    assign o_has_byte       = head.has_byte;
    assign o_first_of_frame = head.first_of_frame;
    assign o_last_of_frame  = head.last_of_frame;

endmodule

// ===== sv/mld_checker.sv =====
module mld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_payload_byte,
    input logic       o_has_byte,
    input logic       o_first_of_frame,
    input logic       o_last_of_frame
);

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input side is open right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // an empty-frame marker is a whole frame with a zero payload
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |->
            (o_first_of_frame && o_last_of_frame && o_payload_byte == 8'd0))
        else $error("malformed empty-frame marker");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_payload_byte) && $stable(o_has_byte)
             && $stable(o_first_of_frame) && $stable(o_last_of_frame)))
        else $error("stalled result changed");

endmodule

bind magic_length_deframer mld_checker u_mld_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_payload_byte   (o_payload_byte),
    .o_has_byte       (o_has_byte),
    .o_first_of_frame (o_first_of_frame),
    .o_last_of_frame  (o_last_of_frame)
);

// ===== sim/magic_length_deframer_test.sv =====
module magic_length_deframer_test;
    import mld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FRAME_SYNC = 64'h3133_7359_3723_337E;
    localparam int DIRECTED_COUNT = 25;
    localparam int TOTAL_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 12;
    localparam t_result NO_RESULT = '0;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA
    } t_hunt_phase;

    // How a stimulus byte is checked: by the predictor, not at all, or against a typed-in result.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_TYPED
    } t_check_kind;

    typedef struct packed {
        logic [7:0]  data;
        t_check_kind kind;
        t_result     want;
    } t_stim_item;

    localparam t_stim_item DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // sync, then length zero: empty-frame marker
        '{8'h31, CHK_NONE, NO_RESULT},
        '{8'h33, CHK_NONE, NO_RESULT},
        '{8'h73, CHK_NONE, NO_RESULT},
        '{8'h59, CHK_NONE, NO_RESULT},
        '{8'h37, CHK_NONE, NO_RESULT},
        '{8'h23, CHK_NONE, NO_RESULT},
        '{8'h33, CHK_NONE, NO_RESULT},
        '{8'h7E, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_TYPED, '{8'h00, 1'b0, 1'b1, 1'b1}},
        // sync, then length one: a single byte opens and closes the frame
        '{8'h31, CHK_NONE, NO_RESULT},
        '{8'h33, CHK_NONE, NO_RESULT},
        '{8'h73, CHK_NONE, NO_RESULT},
        '{8'h59, CHK_NONE, NO_RESULT},
        '{8'h37, CHK_NONE, NO_RESULT},
        '{8'h23, CHK_NONE, NO_RESULT},
        '{8'h33, CHK_NONE, NO_RESULT},
        '{8'h7E, CHK_NONE, NO_RESULT},
        '{8'h01, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'h00, CHK_NONE, NO_RESULT},
        '{8'hFF, CHK_TYPED, '{8'hFF, 1'b1, 1'b1, 1'b1}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_payload_byte;
    logic       o_has_byte;
    logic       o_first_of_frame;
    logic       o_last_of_frame;

    t_stim_item  stim_q[$];
    t_result     expected_q[$];
    int          accepted_count = 0;
    int          fail_count = 0;

    // Deframer state as predicted from the accepted bytes.
    logic [63:0] hunt_window;
    t_hunt_phase hunt_phase;
    logic [1:0]  len_index;
    logic [31:0] len_accum;
    logic [31:0] payload_left;
    logic        frame_opening;

    magic_length_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_byte  (o_payload_byte),
        .o_has_byte      (o_has_byte),
        .o_first_of_frame(o_first_of_frame),
        .o_last_of_frame (o_last_of_frame)
    );

    always #10 i_clk = ~i_clk;

    function automatic void restart_hunt();
        hunt_window   = '0;
        hunt_phase    = PH_HUNT;
        len_index     = '0;
        len_accum     = '0;
        payload_left  = '0;
        frame_opening = 1'b0;
    endfunction

    // Advance the frame state by one byte; return 1 when a result comes out.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result res);
        res = NO_RESULT;
        case (hunt_phase)
            PH_LEN: begin
                len_accum = len_accum | ({24'h0, b} << (8 * len_index));
                if (len_index == 2'd3) begin
                    if (len_accum == 32'h0) begin
                        res = {8'h00, 1'b0, 1'b1, 1'b1};
                        restart_hunt();
                        return 1'b1;
                    end
                    payload_left  = len_accum;
                    frame_opening = 1'b1;
                    len_index     = '0;
                    hunt_phase    = PH_DATA;
                end else begin
                    len_index = len_index + 2'd1;
                end
                return 1'b0;
            end
            PH_DATA: begin
                res = {b, 1'b1, frame_opening, payload_left <= 32'd1};
                frame_opening = 1'b0;
                if (payload_left <= 32'd1)
                    restart_hunt();
                else
                    payload_left = payload_left - 32'd1;
                return 1'b1;
            end
            default: begin
                hunt_window = {hunt_window[55:0], b};
                if (hunt_window == FRAME_SYNC) begin
                    restart_hunt();
                    hunt_phase = PH_LEN;
                end else begin
                    hunt_phase = PH_HUNT;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Mostly a random wait, with occasional calm stretches of none.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stim_q.push_back({b, CHK_PREDICT, NO_RESULT});
    endfunction

    function automatic void add_sync(input int upto);
        for (int j = 0; j < upto; j++)
            add_byte(FRAME_SYNC[63 - 8 * j -: 8]);
    endfunction

    function automatic void add_length(input logic [31:0] len);
        for (int j = 0; j < 4; j++)
            add_byte(len[8 * j +: 8]);
    endfunction

    // Mostly well-formed frames with random content; the rest noise and broken headers.
    function automatic void build_random_stream();
        int          pick;
        int          sync_at;
        logic [31:0] frame_len;

        while (stim_q.size() < TOTAL_ITEMS) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(5, 30)) add_byte(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                // truncated sync, then a stray byte
                add_sync($urandom_range(1, 7));
                add_byte(8'($urandom_range(0, 255)));
            end else if (pick == 2) begin
                // repeated leading bytes must still let the real pattern match
                add_sync($urandom_range(1, 7));
                add_sync(8);
                add_length($urandom_range(0, 6));
                repeat (stim_q.size() % 7) add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_sync(8);
                case ($urandom_range(0, 7))
                    0:       frame_len = 32'd0;
                    1:       frame_len = 32'd1;
                    2:       frame_len = $urandom_range(60, 200);
                    default: frame_len = $urandom_range(2, 24);
                endcase
                add_length(frame_len);
                sync_at = (frame_len >= 8 && $urandom_range(0, 2) == 0) ?
                          $urandom_range(0, frame_len - 8) : -1;
                for (int j = 0; j < frame_len; j++) begin
                    if (j == sync_at) begin
                        add_sync(8);
                        j += 7;
                    end else begin
                        add_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end
        // largest length: the frame stays open to the end of the run
        add_sync(8);
        add_length(32'hFFFF_FFFF);
        repeat (20) add_byte(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Input side: send every byte, waiting a random gap before each transfer.
    initial begin
        int calm_left;
        int gap;

        calm_left = 0;
        restart_hunt();
        foreach (DIRECTED_ROWS[r])
            stim_q.push_back(DIRECTED_ROWS[r]);
        build_random_stream();

        while (!i_rst_n) @(posedge i_clk);
        for (int i = 0; i < stim_q.size(); i++) begin
            gap = draw_gap(calm_left);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_data_byte <= stim_q[i].data;
            do @(posedge i_clk); while (!o_in_ready);
        end
        i_in_valid <= 1'b0;

        while (accepted_count != stim_q.size() || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Output side: stall a random number of cycles before taking each result.
    initial begin
        int calm_left;
        int gap;

        calm_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(calm_left);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_result predicted;
        bit      produced;

        if (i_rst_n && i_in_valid && o_in_ready) begin
            produced = deframe_byte(stim_q[accepted_count].data, predicted);
            case (stim_q[accepted_count].kind)
                CHK_PREDICT: if (produced) expected_q.push_back(predicted);
                CHK_TYPED:   expected_q.push_back(stim_q[accepted_count].want);
                default:     ;
            endcase
            accepted_count++;
        end
    end

    always @(posedge i_clk) begin
        t_result want;

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected transfer: payload_byte %h has_byte %b first %b last %b",
                       o_payload_byte, o_has_byte, o_first_of_frame, o_last_of_frame);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %h, got %h", want.payload_byte,
                           o_payload_byte);
                    fail_count++;
                end
                if (o_has_byte !== want.has_byte) begin
                    $error("has_byte: expected %b, got %b", want.has_byte, o_has_byte);
                    fail_count++;
                end
                if (o_first_of_frame !== want.first_of_frame) begin
                    $error("first_of_frame: expected %b, got %b", want.first_of_frame,
                           o_first_of_frame);
                    fail_count++;
                end
                if (o_last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %b, got %b", want.last_of_frame,
                           o_last_of_frame);
                    fail_count++;
                end
            end
        end
    end

endmodule
